// ===== rtl/core/sync_header_frame_parser_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sync header frame parser
// Concurrent assertions clocked by clk; one form honors rst_n, one does not.
// ----------------------------------------------------------------------------
`ifndef SYNC_HEADER_FRAME_PARSER_UNIT_MACROS_SVH
`define SYNC_HEADER_FRAME_PARSER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define SHFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHFP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHFP_ASSERT(lbl, prop, msg)
`define SHFP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/shfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfp_pkg
// Types and constants shared by the sync header frame parser modules.
// ----------------------------------------------------------------------------
package shfp_pkg;

    localparam logic [7:0] SYNC_1 = 8'h73;
    localparam logic [7:0] SYNC_2 = 8'h6E;
    localparam logic [7:0] SYNC_3 = 8'h70;

    localparam logic [7:0] TYPE_MIN_RESET = 8'hB0;
    localparam logic [7:0] TYPE_MAX_RESET = 8'hC8;

    localparam logic [7:0] CFG_IDX_TYPE_MIN = 8'd0;
    localparam logic [7:0] CFG_IDX_TYPE_MAX = 8'd1;

    typedef enum logic [2:0] {
        PH_SYNC_S  = 3'd0,
        PH_SYNC_N  = 3'd1,
        PH_SYNC_P  = 3'd2,
        PH_TYPE    = 3'd3,
        PH_LEN     = 3'd4,
        PH_DATA    = 3'd5,
        PH_CSUM_LO = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_ACCEPT   = 2'd1,
        KIND_MISMATCH = 2'd2
    } kind_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  packet_type;
        logic [7:0]  payload_byte;
        logic [7:0]  byte_index;
        logic [7:0]  frame_length;
        logic [15:0] received_checksum;
        logic [15:0] computed_checksum;
    } result_t;

endpackage

// ===== rtl/core/shfp_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfp_in_stage
// Input register for received bytes; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module shfp_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] rx_byte
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] rx_byte
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign rx_byte    = byte_reg;

endmodule

// ===== rtl/core/shfp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfp_parser
// Frame state and per-byte parse logic: sync match, type range, length,
// payload pass-through and checksum verdict.
// ----------------------------------------------------------------------------
module shfp_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    input  logic [7:0]       type_min,
    input  logic [7:0]       type_max,
    output shfp_pkg::result_t result
);
    import shfp_pkg::*;

    phase_t      phase_reg,   phase_next;
    logic [7:0]  type_reg,    type_next;
    logic [7:0]  length_reg,  length_next;
    logic [7:0]  count_reg,   count_next;
    logic [15:0] sum_reg,     sum_next;
    logic [7:0]  csum_hi_reg, csum_hi_next;

    logic [15:0] sum_plus;
    logic [15:0] rx_sum;
    logic        is_sync_1;

    assign sum_plus  = sum_reg + {8'd0, rx_byte};
    assign rx_sum    = {csum_hi_reg, rx_byte};
    assign is_sync_1 = (rx_byte == SYNC_1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SYNC_S;
            type_reg    <= 8'd0;
            length_reg  <= 8'd0;
            count_reg   <= 8'd0;
            sum_reg     <= 16'd0;
            csum_hi_reg <= 8'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            type_reg    <= type_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            csum_hi_reg <= csum_hi_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        csum_hi_next = csum_hi_reg;

        result                   = '0;
        result.kind              = KIND_PAYLOAD;
        result.packet_type       = type_reg;
        result.frame_length      = length_reg;
        result.computed_checksum = sum_reg;

        case (phase_reg)
            PH_SYNC_S:
            begin
                if (is_sync_1)
                begin
                    phase_next = PH_SYNC_N;
                    sum_next   = {8'd0, SYNC_1};
                end
            end
            PH_SYNC_N, PH_SYNC_P, PH_TYPE:
            begin
                if ((phase_reg == PH_SYNC_N && rx_byte == SYNC_2) ||
                    (phase_reg == PH_SYNC_P && rx_byte == SYNC_3))
                begin
                    phase_next = (phase_reg == PH_SYNC_N) ? PH_SYNC_P : PH_TYPE;
                    sum_next   = sum_plus;
                end
                else if (phase_reg == PH_TYPE && rx_byte >= type_min &&
                         rx_byte <= type_max)
                begin
                    type_next  = rx_byte;
                    phase_next = PH_LEN;
                    sum_next   = sum_plus;
                end
                else if (is_sync_1)
                begin
                    // restart at the second sync byte
                    phase_next = PH_SYNC_N;
                    sum_next   = {8'd0, SYNC_1};
                end
                else
                begin
                    phase_next = PH_SYNC_S;
                end
            end
            PH_LEN:
            begin
                length_next = rx_byte;
                count_next  = 8'd0;
                phase_next  = PH_DATA;
                sum_next    = sum_plus;
            end
            PH_DATA:
            begin
                if (count_reg < length_reg)
                begin
                    sum_next                 = sum_plus;
                    count_next               = count_reg + 8'd1;
                    result.valid             = 1'b1;
                    result.kind              = KIND_PAYLOAD;
                    result.payload_byte      = rx_byte;
                    result.byte_index        = count_reg;
                    result.computed_checksum = sum_plus;
                end
                else
                begin
                    csum_hi_next = rx_byte;
                    phase_next   = PH_CSUM_LO;
                end
            end
            PH_CSUM_LO:
            begin
                result.valid             = 1'b1;
                result.received_checksum = rx_sum;
                if (rx_sum == sum_reg)
                begin
                    result.kind = KIND_ACCEPT;
                    phase_next  = PH_SYNC_S;
                end
                else
                begin
                    result.kind = KIND_MISMATCH;
                    if (is_sync_1)
                    begin
                        phase_next = PH_SYNC_N;
                        sum_next   = {8'd0, SYNC_1};
                    end
                    else
                    begin
                        phase_next = PH_SYNC_S;
                    end
                end
            end
            default:
            begin
                if (is_sync_1)
                begin
                    phase_next = PH_SYNC_N;
                    sum_next   = {8'd0, SYNC_1};
                end
                else
                begin
                    phase_next = PH_SYNC_S;
                end
            end
        endcase
    end

endmodule

// ===== rtl/core/shfp_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfp_out_stage
// Result register driving the master stream; holds while the sink stalls.
// ----------------------------------------------------------------------------
module shfp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  shfp_pkg::result_t result,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,   // packet_type, payload_byte, byte_index,
                                         // frame_length, received_checksum,
                                         // computed_checksum
    output logic [1:0]        m_tuser    // result_kind
);
    import shfp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.computed_checksum, data_reg.received_checksum,
                       data_reg.frame_length, data_reg.byte_index,
                       data_reg.payload_byte, data_reg.packet_type};
    assign m_tuser  = data_reg.kind;

endmodule

// ===== rtl/core/sync_header_frame_parser_unit.sv =====
`timescale 1ns / 1ps
`include "sync_header_frame_parser_unit_macros.svh"
// ----------------------------------------------------------------------------
// sync_header_frame_parser_unit
// Byte-serial frame parser: sync "snp", type, length, payload, 16-bit sum.
//
// Slave stream s_*: one received byte per transaction in s_tdata[7:0].
// Master stream m_*: one result per payload byte or checksum verdict;
//   m_tuser holds the kind (payload, frame accepted, checksum mismatch),
//   m_tdata the frame fields. Header and checksum-high bytes give no result.
// Config channel cfg_*: cfg_index 0 writes type_min, 1 writes type_max,
//   other indexes are ignored; cfg_ready is always high. Write only while
//   no byte is in flight.
// Path: an accepted byte waits in the input register, then its result,
//   if any, is parsed into the result register. Throughput: one byte per
//   cycle while m_* does not stall; the parse step is combinational.
// Reset: parser waits for the first sync byte, type range 0xB0..0xC8,
//   both registers empty.
// Stall: the result register holds while m_tready is low; one more byte
//   waits in the input register, then s_tready drops.
// ----------------------------------------------------------------------------
module sync_header_frame_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // [7:0] packet_type, [15:8] payload_byte,
                                     // [23:16] byte_index, [31:24] frame_length,
                                     // [47:32] received_checksum,
                                     // [63:48] computed_checksum
    output logic [1:0]  m_tuser,     // [1:0] result_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import shfp_pkg::*;

    logic       type_min_sel;
    logic [7:0] type_min_reg;
    logic [7:0] type_max_reg;
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       advance;
    result_t    result;

    assign cfg_ready    = 1'b1;
    assign type_min_sel = (cfg_index == CFG_IDX_TYPE_MIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_min_reg <= TYPE_MIN_RESET;
            type_max_reg <= TYPE_MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (type_min_sel)
            begin
                type_min_reg <= cfg_data;
            end
            else if (cfg_index == CFG_IDX_TYPE_MAX)
            begin
                type_max_reg <= cfg_data;
            end
        end
    end

    // advance the held byte when the result register can take its result
    assign advance = byte_valid && (!m_tvalid || m_tready);

    shfp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte)
    );

    shfp_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .rx_byte  (rx_byte),
        .type_min (type_min_reg),
        .type_max (type_max_reg),
        .result   (result)
    );

    shfp_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && result.valid),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `SHFP_ASSERT(a_payload_no_rx_sum,
        m_tvalid && m_tuser == KIND_PAYLOAD |->
            m_tdata[47:32] == 16'd0 && m_tdata[23:16] < m_tdata[31:24],
        "payload result with bad index or checksum field")
    `SHFP_ASSERT(a_verdict_no_payload,
        m_tvalid && m_tuser != KIND_PAYLOAD |-> m_tdata[23:8] == 16'd0,
        "verdict result carries payload fields")
    `SHFP_ASSERT(a_backpressure,
        !s_tready |-> m_tvalid && !m_tready,
        "input stalled without output stall")
    `SHFP_ASSERT_RST(a_reset_empty,
        !rst_n |-> !m_tvalid,
        "result valid during reset")

endmodule

// ===== bench/shfp_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfp_frame_checker
// Watches the byte, result and config channels of the frame parser. Every
// accepted byte runs through a local parser model. The model queues the
// payload and verdict results that the byte produces. Each result transaction
// is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module shfp_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          mismatches,
    output int          outstanding
);
    import shfp_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ptype;
        logic [7:0]  pbyte;
        logic [7:0]  idx;
        logic [7:0]  flen;
        logic [15:0] rx_sum;
        logic [15:0] calc_sum;
    } frame_result_t;

    frame_result_t due_results[$];
    frame_result_t want;

    phase_t      phase;
    logic [7:0]  type_lo;
    logic [7:0]  type_hi;
    logic [7:0]  cur_type;
    logic [7:0]  cur_len;
    logic [7:0]  cur_cnt;
    logic [7:0]  csum_hi;
    logic [15:0] run_sum;

    // Drop back to the first sync byte, or take an 's' as a fresh start.
    task automatic restart_on(input logic [7:0] c);
        if (c == SYNC_1)
        begin
            phase   = PH_SYNC_N;
            run_sum = {8'h00, SYNC_1};
        end
        else
            phase = PH_SYNC_S;
    endtask

    task automatic parse_byte(input logic [7:0] c);
        frame_result_t r;
        logic [15:0]   rx;
        r = '0;
        case (phase)
            PH_SYNC_S:
                if (c == SYNC_1)
                begin
                    phase   = PH_SYNC_N;
                    run_sum = {8'h00, SYNC_1};
                end
            PH_SYNC_N:
                if (c == SYNC_2)
                begin
                    phase   = PH_SYNC_P;
                    run_sum = run_sum + c;
                end
                else
                    restart_on(c);
            PH_SYNC_P:
                if (c == SYNC_3)
                begin
                    phase   = PH_TYPE;
                    run_sum = run_sum + c;
                end
                else
                    restart_on(c);
            PH_TYPE:
                if (c >= type_lo && c <= type_hi)
                begin
                    cur_type = c;
                    phase    = PH_LEN;
                    run_sum  = run_sum + c;
                end
                else
                    restart_on(c);
            PH_LEN:
            begin
                cur_len = c;
                cur_cnt = 8'h00;
                phase   = PH_DATA;
                run_sum = run_sum + c;
            end
            PH_DATA:
                if (cur_cnt < cur_len)
                begin
                    run_sum    = run_sum + c;
                    r.kind     = KIND_PAYLOAD;
                    r.ptype    = cur_type;
                    r.pbyte    = c;
                    r.idx      = cur_cnt;
                    r.flen     = cur_len;
                    r.calc_sum = run_sum;
                    due_results.push_back(r);
                    cur_cnt    = cur_cnt + 8'd1;
                end
                else
                begin
                    csum_hi = c;
                    phase   = PH_CSUM_LO;
                end
            PH_CSUM_LO:
            begin
                rx         = {csum_hi, c};
                r.kind     = (rx == run_sum) ? KIND_ACCEPT : KIND_MISMATCH;
                r.ptype    = cur_type;
                r.flen     = cur_len;
                r.rx_sum   = rx;
                r.calc_sum = run_sum;
                due_results.push_back(r);
                if (rx == run_sum)
                    phase = PH_SYNC_S;
                else
                    restart_on(c);
            end
            default:
                restart_on(c);
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] got_val);
        if (exp_val !== got_val)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_val, got_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase       = PH_SYNC_S;
            type_lo     = TYPE_MIN_RESET;
            type_hi     = TYPE_MAX_RESET;
            cur_type    = 8'h00;
            cur_len     = 8'h00;
            cur_cnt     = 8'h00;
            csum_hi     = 8'h00;
            run_sum     = 16'h0000;
            mismatches  = 0;
            due_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_IDX_TYPE_MIN)
                    type_lo = cfg_data;
                else if (cfg_index == CFG_IDX_TYPE_MAX)
                    type_hi = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result transaction with none pending: tuser %0h tdata %0h",
                           m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("result_kind",       16'(want.kind), 16'(m_tuser));
                    check_field("packet_type",       16'(want.ptype), 16'(m_tdata[7:0]));
                    check_field("payload_byte",      16'(want.pbyte), 16'(m_tdata[15:8]));
                    check_field("byte_index",        16'(want.idx), 16'(m_tdata[23:16]));
                    check_field("frame_length",      16'(want.flen), 16'(m_tdata[31:24]));
                    check_field("received_checksum", want.rx_sum, m_tdata[47:32]);
                    check_field("computed_checksum", want.calc_sum, m_tdata[63:48]);
                end
            end
            if (s_tvalid && s_tready)
                parse_byte(s_tdata);
            outstanding = due_results.size();
        end
    end

endmodule

// ===== bench/sync_header_frame_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_header_frame_parser_unit_tb
// Feeds the parser framed and broken byte streams under several type ranges,
// with random gaps on the byte stream and random stalls on the result stream.
// The checker instance compares results and reports the mismatch count.
// ----------------------------------------------------------------------------
module sync_header_frame_parser_unit_tb;
    import shfp_pkg::*;

    localparam int LIMIT = 1_000_000;

    typedef enum int {
        CSUM_GOOD,
        CSUM_BAD,
        CSUM_BAD_SYNC
    } csum_mode_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_index = 8'h00;
    logic [7:0]  cfg_data  = 8'h00;
    wire         s_tready;
    wire         m_tvalid;
    wire  [63:0] m_tdata;
    wire  [1:0]  m_tuser;
    wire         cfg_ready;

    int          mismatches;
    int          outstanding;
    int          cycles     = 0;
    int          sink_hold  = 0;
    int          bytes_sent = 0;
    bit          no_idle    = 1'b0;
    logic [7:0]  tx_bytes[$];
    logic [7:0]  cur_lo     = TYPE_MIN_RESET;
    logic [7:0]  cur_hi     = TYPE_MAX_RESET;

    sync_header_frame_parser_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    shfp_frame_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(posedge clk)
    begin
        if (sink_hold > 0)
            sink_hold--;
        else
            sink_hold = pick_gap();
        m_tready <= (sink_hold == 0);
    end

    function automatic logic [7:0] pick_type(input bit in_range);
        if (cur_lo > cur_hi)
            return 8'($urandom);
        if (in_range)
            return 8'($urandom_range(cur_lo, cur_hi));
        if (cur_lo != 8'h00 && (cur_hi == 8'hFF || $urandom_range(0, 1)))
            return 8'($urandom_range(0, cur_lo - 8'd1));
        if (cur_hi != 8'hFF)
            return 8'($urandom_range(cur_hi + 8'd1, 255));
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return 8'($urandom_range(0, 6));
        if (r < 98)
            return 8'($urandom_range(7, 40));
        return 8'($urandom_range(41, 255));
    endfunction

    // Hold tvalid high across back-to-back bytes; lower it only for a gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic flush_bytes();
        foreach (tx_bytes[i])
            send_byte(tx_bytes[i]);
        tx_bytes.delete();
    endtask

    // Append one frame; with after_sync the leading 's' is left out because
    // the byte before it already restarted the parser.
    task automatic queue_frame(input logic [7:0] ftype, input logic [7:0] flen,
                               input csum_mode_t mode, input bit after_sync);
        logic [15:0] sum;
        logic [15:0] rx;
        logic [7:0]  b;
        sum = 16'(SYNC_1) + 16'(SYNC_2) + 16'(SYNC_3) + 16'(ftype) + 16'(flen);
        if (!after_sync)
            tx_bytes.push_back(SYNC_1);
        tx_bytes.push_back(SYNC_2);
        tx_bytes.push_back(SYNC_3);
        tx_bytes.push_back(ftype);
        tx_bytes.push_back(flen);
        for (int i = 0; i < flen; i++)
        begin
            b   = 8'($urandom);
            sum = sum + b;
            tx_bytes.push_back(b);
        end
        case (mode)
            CSUM_GOOD:
                rx = sum;
            CSUM_BAD:
                rx = sum ^ 16'($urandom_range(1, 65535));
            default:
                rx = {(sum[7:0] == SYNC_1) ? ~sum[15:8] : sum[15:8], SYNC_1};
        endcase
        tx_bytes.push_back(rx[15:8]);
        tx_bytes.push_back(rx[7:0]);
    endtask

    // Wait for the last result, then for bytes that give none to pass through.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_type_range(input logic [7:0] lo, input logic [7:0] hi,
                                  input bit stray);
        drain();
        if (stray)
            write_reg(8'($urandom_range(2, 255)), 8'($urandom));
        write_reg(CFG_IDX_TYPE_MIN, lo);
        write_reg(CFG_IDX_TYPE_MAX, hi);
        cfg_valid <= 1'b0;
        cur_lo = lo;
        cur_hi = hi;
    endtask

    task automatic random_traffic(input int count);
        int         target;
        int         r;
        int         p;
        csum_mode_t mode;
        target = bytes_sent + count;
        while (bytes_sent < target)
        begin
            no_idle = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                p = $urandom_range(0, 99);
                mode = (p < 78) ? CSUM_GOOD : (p < 93) ? CSUM_BAD : CSUM_BAD_SYNC;
                queue_frame(pick_type($urandom_range(0, 9) != 0), pick_len(), mode, 1'b0);
                if (mode == CSUM_BAD_SYNC)
                    queue_frame(pick_type(1'b1), pick_len(), CSUM_GOOD, 1'b1);
            end
            else if (r < 85)
            begin
                // Break a frame: replace one byte, often cutting the rest off.
                queue_frame(pick_type(1'b1), pick_len(), CSUM_GOOD, 1'b0);
                p = $urandom_range(1, tx_bytes.size() - 1);
                tx_bytes[p] = $urandom_range(0, 1) ? SYNC_1 : 8'($urandom);
                if ($urandom_range(0, 1))
                    tx_bytes = tx_bytes[0:p];
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    case ($urandom_range(0, 4))
                        0:       tx_bytes.push_back(SYNC_1);
                        1:       tx_bytes.push_back(SYNC_2);
                        2:       tx_bytes.push_back(SYNC_3);
                        default: tx_bytes.push_back(8'($urandom));
                    endcase
                end
            end
            flush_bytes();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        logic [7:0] lo;
        logic [7:0] hi;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset range: extremes of the byte, boundary types, empty payload,
        // slip on a repeated 's', mismatch ending in 's' with the frame
        // continuing, and types just outside the range.
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hFF);
        queue_frame(TYPE_MIN_RESET, 8'd0, CSUM_GOOD, 1'b0);
        tx_bytes.push_back(SYNC_1);
        queue_frame(TYPE_MAX_RESET, 8'd1, CSUM_GOOD, 1'b0);
        queue_frame(TYPE_MIN_RESET - 8'd1, 8'd1, CSUM_GOOD, 1'b0);
        queue_frame(TYPE_MAX_RESET + 8'd1, 8'd0, CSUM_GOOD, 1'b0);
        queue_frame(8'hB5, 8'd2, CSUM_BAD, 1'b0);
        queue_frame(8'hC0, 8'd1, CSUM_BAD_SYNC, 1'b0);
        queue_frame(8'hC0, 8'd0, CSUM_GOOD, 1'b1);
        flush_bytes();

        set_type_range(8'h00, 8'hFF, 1'b1);
        queue_frame(8'h00, 8'd255, CSUM_GOOD, 1'b0);
        queue_frame(8'hFF, 8'd0, CSUM_BAD, 1'b0);
        flush_bytes();
        random_traffic(400);

        lo = 8'($urandom_range(0, 200));
        hi = 8'($urandom_range(lo, 255));
        set_type_range(lo, hi, 1'b1);
        random_traffic(400);

        lo = 8'($urandom);
        set_type_range(lo, lo, 1'b0);
        random_traffic(350);

        // Inverted range: every type is rejected.
        lo = 8'($urandom_range(1, 255));
        hi = 8'($urandom_range(0, lo - 8'd1));
        set_type_range(lo, hi, 1'b0);
        random_traffic(60);

        set_type_range(8'hFF, 8'hFF, 1'b0);
        random_traffic(220);

        set_type_range(8'h00, 8'h00, 1'b0);
        random_traffic(120);

        drain();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sync_header_frame_parser_unit.f =====
+incdir+rtl/core
rtl/core/shfp_pkg.sv
rtl/core/shfp_in_stage.sv
rtl/core/shfp_parser.sv
rtl/core/shfp_out_stage.sv
rtl/core/sync_header_frame_parser_unit.sv
bench/shfp_frame_checker.sv
bench/sync_header_frame_parser_unit_tb.sv
